### rtl/kcop_pkg.sv
package kcop_pkg;

  localparam int KEY_COUNT = 5;
  localparam int K_UP      = 0;
  localparam int K_DOWN    = 1;
  localparam int K_LEFT    = 2;
  localparam int K_RIGHT   = 3;
  localparam int K_OFF     = 4;

  localparam logic [1:0] CURSOR_MAX = 2'd3;

  typedef logic [7:0] cnt_t;
  typedef logic [1:0] hold_t;
  typedef logic [1:0] row_t;
  typedef logic [3:0] bits_t;
  typedef logic [1:0] cfg_idx_t;

  localparam hold_t HOLD_START = 2'd2;

  localparam cfg_idx_t CFG_ACCEPT_COUNT = 2'd0;
  localparam cfg_idx_t CFG_SLOW_REPEAT  = 2'd1;
  localparam cfg_idx_t CFG_FAST_REPEAT  = 2'd2;

  localparam cnt_t ACCEPT_RESET = 8'd5;
  localparam cnt_t SLOW_RESET   = 8'd75;
  localparam cnt_t FAST_RESET   = 8'd30;

  typedef enum logic [1:0] {
    LANE_KEEP,
    LANE_INC,
    LANE_CLEAR
  } lane_mode_t;

  typedef struct packed {
    cnt_t  count;
    hold_t hold;
    logic  hit;
  } lane_out_t;

  typedef struct packed {
    row_t  cursor_row;
    bits_t output_bits;
    logic  beep_up;
    logic  beep_down;
    logic  beep_activate;
    logic  beep_deactivate;
    logic  settings_reset;
  } result_t;

endpackage

### rtl/keypad_cursor_output_panel_top.sv
// keypad scan panel: every accepted input beat is one scan tick with five key levels and
// returns exactly one result beat. a scan is registered once: the five per-key counter
// lanes and the merge of their actions sit between the key state registers and the output
// register, so a new scan is accepted in every cycle, also while a result waits on out_ready
// as long as that result is taken in the same cycle. configuration writes take effect at
// once and are meant for idle times only.
module keypad_cursor_output_panel_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_up_pressed,
  input  logic                in_down_pressed,
  input  logic                in_left_pressed,
  input  logic                in_right_pressed,
  input  logic                in_off_pressed,
  output logic                out_valid,
  input  logic                out_ready,
  output kcop_pkg::row_t      out_cursor_row,
  output kcop_pkg::bits_t     out_output_bits,
  output logic                out_beep_up,
  output logic                out_beep_down,
  output logic                out_beep_activate,
  output logic                out_beep_deactivate,
  output logic                out_settings_reset,
  input  logic                cfg_we,
  input  kcop_pkg::cfg_idx_t  cfg_index,
  input  kcop_pkg::cnt_t      cfg_data
);
  import kcop_pkg::*;

  cnt_t      accept_r;
  cnt_t      slow_r;
  cnt_t      fast_r;
  cnt_t      count_r    [KEY_COUNT];
  hold_t     hold_r     [KEY_COUNT];
  row_t      cursor_r;
  bits_t     bits_r;
  logic      out_valid_r;
  result_t   result_r;

  lane_mode_t mode     [KEY_COUNT];
  lane_out_t  lanes    [KEY_COUNT];
  hold_t      hold_nxt [KEY_COUNT];
  row_t       cursor_nxt;
  bits_t      bits_nxt;
  result_t    result_nxt;
  logic       all_arrows;
  logic       in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign all_arrows = in_up_pressed && in_down_pressed && in_left_pressed && in_right_pressed;

  // all four arrows together count jointly and leave off alone
  always_comb begin
    if (all_arrows) begin
      mode[K_UP]    = LANE_INC;
      mode[K_DOWN]  = LANE_INC;
      mode[K_LEFT]  = LANE_INC;
      mode[K_RIGHT] = LANE_INC;
      mode[K_OFF]   = LANE_KEEP;
    end else begin
      mode[K_UP]    = (in_up_pressed && !in_down_pressed) ? LANE_INC : LANE_CLEAR;
      mode[K_DOWN]  = (in_down_pressed && !in_up_pressed) ? LANE_INC : LANE_CLEAR;
      mode[K_LEFT]  = (in_left_pressed && !in_right_pressed) ? LANE_INC : LANE_CLEAR;
      mode[K_RIGHT] = (in_right_pressed && !in_left_pressed) ? LANE_INC : LANE_CLEAR;
      mode[K_OFF]   = in_off_pressed ? LANE_INC : LANE_CLEAR;
    end
  end

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    kcop_lane u_lane (
      .mode         (mode[k]),
      .count        (count_r[k]),
      .hold         (hold_r[k]),
      .accept_count (accept_r),
      .slow_repeat  (slow_r),
      .fast_repeat  (fast_r),
      .lane_out     (lanes[k])
    );
  end

  kcop_merge u_merge (
    .lanes        (lanes),
    .cursor       (cursor_r),
    .out_bits     (bits_r),
    .hold_nxt     (hold_nxt),
    .cursor_nxt   (cursor_nxt),
    .out_bits_nxt (bits_nxt),
    .result       (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_r <= ACCEPT_RESET;
      slow_r   <= SLOW_RESET;
      fast_r   <= FAST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEPT_COUNT: accept_r <= cfg_data;
        CFG_SLOW_REPEAT:  slow_r   <= cfg_data;
        CFG_FAST_REPEAT:  fast_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        count_r[k] <= '0;
        hold_r[k]  <= HOLD_START;
      end
      cursor_r <= '0;
      bits_r   <= '0;
    end else if (in_fire) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        count_r[k] <= lanes[k].count;
        hold_r[k]  <= hold_nxt[k];
      end
      cursor_r <= cursor_nxt;
      bits_r   <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_row      = result_r.cursor_row;
  assign out_output_bits     = result_r.output_bits;
  assign out_beep_up         = result_r.beep_up;
  assign out_beep_down       = result_r.beep_down;
  assign out_beep_activate   = result_r.beep_activate;
  assign out_beep_deactivate = result_r.beep_deactivate;
  assign out_settings_reset  = result_r.settings_reset;

endmodule

### rtl/kcop_lane.sv
module kcop_lane (
  input  kcop_pkg::lane_mode_t mode,
  input  kcop_pkg::cnt_t       count,
  input  kcop_pkg::hold_t      hold,
  input  kcop_pkg::cnt_t       accept_count,
  input  kcop_pkg::cnt_t       slow_repeat,
  input  kcop_pkg::cnt_t       fast_repeat,
  output kcop_pkg::lane_out_t  lane_out
);
  import kcop_pkg::*;

  cnt_t  cnt;
  hold_t hld;
  cnt_t  wrapped;

  always_comb begin
    cnt = count;
    hld = hold;
    case (mode)
      LANE_INC: begin
        cnt = count + 8'd1;
      end
      LANE_CLEAR: begin
        cnt = '0;
        hld = HOLD_START;
      end
      default: begin
        cnt = count;
      end
    endcase

    // fast period applies once the hold count has run out
    if (hld == 2'd0 && cnt >= fast_repeat) begin
      wrapped = '0;
    end else if (cnt >= slow_repeat) begin
      wrapped = '0;
    end else begin
      wrapped = cnt;
    end

    lane_out.count = wrapped;
    lane_out.hold  = hld;
    lane_out.hit   = (wrapped == accept_count);
  end

endmodule

### rtl/kcop_merge.sv
module kcop_merge (
  input  kcop_pkg::lane_out_t lanes [kcop_pkg::KEY_COUNT],
  input  kcop_pkg::row_t      cursor,
  input  kcop_pkg::bits_t     out_bits,
  output kcop_pkg::hold_t     hold_nxt [kcop_pkg::KEY_COUNT],
  output kcop_pkg::row_t      cursor_nxt,
  output kcop_pkg::bits_t     out_bits_nxt,
  output kcop_pkg::result_t   result
);
  import kcop_pkg::*;

  row_t  cur;
  bits_t bits;
  hold_t h_up;
  hold_t h_dn;
  hold_t h_lf;
  hold_t h_rt;
  logic  b_up;
  logic  b_dn;
  logic  b_act;
  logic  b_deact;
  logic  b_rst;

  always_comb begin
    cur     = cursor;
    bits    = out_bits;
    h_up    = lanes[K_UP].hold;
    h_dn    = lanes[K_DOWN].hold;
    h_lf    = lanes[K_LEFT].hold;
    h_rt    = lanes[K_RIGHT].hold;
    b_up    = 1'b0;
    b_dn    = 1'b0;
    b_act   = 1'b0;
    b_deact = 1'b0;

    // actions apply in key order: up, down, left, right
    if (lanes[K_UP].hit) begin
      cur = (cur != 2'd0) ? cur - 2'd1 : CURSOR_MAX;
      if (h_up != 2'd0) h_up = h_up - 2'd1;
      b_up = 1'b1;
    end
    if (lanes[K_DOWN].hit) begin
      cur = (cur < CURSOR_MAX) ? cur + 2'd1 : 2'd0;
      if (h_dn != 2'd0) h_dn = h_dn - 2'd1;
      b_dn = 1'b1;
    end
    if (lanes[K_LEFT].hit && h_lf != 2'd0) begin
      if (bits[cur]) begin
        bits[cur] = 1'b0;
        b_deact   = 1'b1;
      end
      h_lf = 2'd0;
    end
    if (lanes[K_RIGHT].hit && h_rt != 2'd0) begin
      if (!bits[cur]) begin
        bits[cur] = 1'b1;
        b_act     = 1'b1;
      end
      h_rt = 2'd0;
    end

    b_rst = (h_up == 2'd0) && (h_dn == 2'd0) && (h_lf == 2'd0) && (h_rt == 2'd0);
    if (b_rst) begin
      h_up = HOLD_START;
      h_dn = HOLD_START;
      h_lf = HOLD_START;
      h_rt = HOLD_START;
    end

    hold_nxt[K_UP]    = h_up;
    hold_nxt[K_DOWN]  = h_dn;
    hold_nxt[K_LEFT]  = h_lf;
    hold_nxt[K_RIGHT] = h_rt;
    hold_nxt[K_OFF]   = lanes[K_OFF].hold;
    cursor_nxt        = cur;
    out_bits_nxt      = bits;

    result.cursor_row      = cur;
    result.output_bits     = bits;
    result.beep_up         = b_up;
    result.beep_down       = b_dn;
    result.beep_activate   = b_act;
    result.beep_deactivate = b_deact;
    result.settings_reset  = b_rst;
  end

endmodule

### rtl/kcop_checker.sv
module kcop_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input kcop_pkg::row_t     out_cursor_row,
  input kcop_pkg::bits_t    out_output_bits,
  input logic               out_beep_activate,
  input logic               out_beep_deactivate
);
  import kcop_pkg::*;

  // output register frees up whenever nothing is held
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_row)
      && $stable(out_output_bits))
    else $error("stalled result beat changed");

  // right acts last, so a switch-on leaves the selected bit set
  a_activate_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep_activate |-> out_output_bits[out_cursor_row])
    else $error("activate beat without selected bit set");

  a_deactivate_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep_deactivate && !out_beep_activate
      |-> !out_output_bits[out_cursor_row])
    else $error("deactivate beat with selected bit still set");

endmodule

bind keypad_cursor_output_panel_top kcop_checker u_kcop_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_cursor_row      (out_cursor_row),
  .out_output_bits     (out_output_bits),
  .out_beep_activate   (out_beep_activate),
  .out_beep_deactivate (out_beep_deactivate)
);
